// ===== src/srt_pkg.sv =====
`default_nettype none

package srt_pkg;

  localparam int unsigned DEPTH = 64;

  typedef logic signed [31:0] value_t;

  typedef struct packed {
    logic insert;
    logic shift;
  } cell_ctrl_t;

  typedef struct packed {
    value_t value;
    logic   occ;
    logic   gt;
  } cell_link_t;

endpackage

`default_nettype wire

// ===== src/insertion_sorter.sv =====
`default_nettype none

// Stable insertion sorter for sets of up to srt_pkg::DEPTH signed 32-bit values.
// Send one value per beat on the input channel with end_of_set on the final
// one; each value is placed into a row of compare-and-shift cells at its
// sorted position. On the final beat, or on the beat that fills the row, the
// row drains from its low end one beat per cycle while out_stall allows it,
// in ascending order (equal values in arrival order), with last_out on the
// final beat. in_stall stays high while the row drains, so no value of a new
// set is taken until the previous set has drained.
module insertion_sorter (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic signed [31:0]  sample_value,
  input  wire logic                end_of_set,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic signed [31:0]       sorted_value,
  output logic                     last_out
);

  srt_pkg::cell_ctrl_t ctrl;
  srt_pkg::cell_link_t links [srt_pkg::DEPTH];
  srt_pkg::cell_link_t lower [srt_pkg::DEPTH];
  srt_pkg::cell_link_t upper [srt_pkg::DEPTH];
  logic [srt_pkg::DEPTH-1:0] occ;
  logic draining;
  logic draining_next;
  logic load;

  assign ctrl.insert = in_valid && !draining;
  assign load        = draining && (!out_valid || !out_stall);
  assign ctrl.shift  = load;
  assign in_stall    = draining;

  genvar i;
  generate
    for (i = 0; i < srt_pkg::DEPTH; i++) begin : g_cell
      if (i == 0) begin : g_low
        assign lower[i] = '{value: '0, occ: 1'b1, gt: 1'b0};
      end else begin : g_mid
        assign lower[i] = links[i-1];
      end
      if (i == srt_pkg::DEPTH - 1) begin : g_top
        assign upper[i] = '{value: '0, occ: 1'b0, gt: 1'b1};
      end else begin : g_below
        assign upper[i] = links[i+1];
      end
      assign occ[i] = links[i].occ;

      srt_cell u_cell (
        .clk    (clk),
        .rst    (rst),
        .ctrl   (ctrl),
        .sample (sample_value),
        .lower  (lower[i]),
        .upper  (upper[i]),
        .link   (links[i])
      );
    end
  endgenerate

  always_comb begin
    draining_next = draining;
    if (ctrl.insert && (end_of_set || occ[srt_pkg::DEPTH-2])) begin
      draining_next = 1'b1;
    end else if (load && !occ[1]) begin
      draining_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      draining  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      draining <= draining_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      sorted_value <= links[0].value;
      last_out     <= !occ[1];
    end
  end

`ifndef SYNTHESIS
  a_drain_has_data: assert property (@(posedge clk) disable iff (rst)
    draining |-> occ[0])
    else $error("draining with an empty row");

  a_insert_fills_low: assert property (@(posedge clk) disable iff (rst)
    ctrl.insert |=> occ[0])
    else $error("insert left the low cell empty");

  a_final_starts_drain: assert property (@(posedge clk) disable iff (rst)
    ctrl.insert && end_of_set |=> draining)
    else $error("final beat did not start the drain");

  a_full_only_draining: assert property (@(posedge clk) disable iff (rst)
    !draining |-> !occ[srt_pkg::DEPTH-1])
    else $error("row full outside of a drain");

  a_occ_contiguous: assert property (@(posedge clk) disable iff (rst)
    (occ & (occ + 1'b1)) == '0)
    else $error("occupied cells not packed at the low end");
`endif

endmodule

`default_nettype wire

// ===== src/srt_cell.sv =====
`default_nettype none

module srt_cell (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire srt_pkg::cell_ctrl_t ctrl,
  input  wire srt_pkg::value_t    sample,
  input  wire srt_pkg::cell_link_t lower,
  input  wire srt_pkg::cell_link_t upper,
  output srt_pkg::cell_link_t     link
);

  srt_pkg::value_t value;
  logic            occ;
  logic            gt;

  assign gt = !occ || (value > sample);

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      value <= upper.value;
    end else if (ctrl.insert && gt) begin
      value <= lower.gt ? lower.value : sample;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= 1'b0;
    end else if (ctrl.shift) begin
      occ <= upper.occ;
    end else if (ctrl.insert) begin
      occ <= occ | lower.occ;
    end
  end

  assign link.value = value;
  assign link.occ   = occ;
  assign link.gt    = gt;

endmodule

`default_nettype wire
